>>> rtl/core/rtpq_pkg.sv
// Package: constants, types and lookup functions for the terminal palette quantizer.
`timescale 1ns / 1ps

package rtpq_pkg;

    // Field widths
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned CH_W    = 8;

    // Internal widths
    localparam int unsigned SUM_W   = 10;  // r+g+b up to 765
    localparam int unsigned CSQ_W   = 12;  // cube channel error, diff up to 47
    localparam int unsigned CERR_W  = 14;  // three cube channel errors
    localparam int unsigned SQ_W    = 16;  // full 8-bit diff squared
    localparam int unsigned DIST_W  = 18;  // three full squares
    localparam int unsigned STEP_W  = 5;   // grey step 0..23
    localparam int unsigned CIDX_W  = 3;   // cube level 0..5
    localparam int unsigned AIDX_W  = 4;   // ansi color 0..15
    localparam int unsigned ACODE_W = 2;   // ansi channel level code

    // Floor divide by 3 via reciprocal, exact for sums up to 765
    localparam logic [SUM_W-1:0] MEAN_RECIP = 10'd683;
    localparam int unsigned      MEAN_SHIFT = 11;
    // Floor divide by 10 via reciprocal, exact for values up to 234
    localparam logic [CH_W-1:0]  STEP_RECIP = 8'd205;
    localparam int unsigned      STEP_SHIFT = 11;

    // Grey ramp limits
    localparam logic [CH_W-1:0]   GREY_LO     = 8'd8;
    localparam logic [CH_W-1:0]   GREY_HI     = 8'd238;
    localparam logic [CH_W-1:0]   GREY_OFS    = 8'd3;
    localparam logic [STEP_W-1:0] GREY_MAX    = 5'd23;
    localparam logic [CH_W-1:0]   GREY_BASE_L = 8'd8;
    localparam logic [CH_W-1:0]   GREY_STRIDE = 8'd10;

    // Palette index bases
    localparam logic [INDEX_W-1:0] GREY_BASE = 8'd232;
    localparam logic [INDEX_W-1:0] CUBE_BASE = 8'd16;
    localparam logic [INDEX_W-1:0] CUBE_R_WT = 8'd36;
    localparam logic [INDEX_W-1:0] CUBE_G_WT = 8'd6;

    // Palette modes
    localparam logic MODE_CUBE = 1'b0;
    localparam logic MODE_ANSI = 1'b1;

    // ANSI channel level codes
    localparam logic [ACODE_W-1:0] AC_00 = 2'd0;
    localparam logic [ACODE_W-1:0] AC_80 = 2'd1;
    localparam logic [ACODE_W-1:0] AC_C0 = 2'd2;
    localparam logic [ACODE_W-1:0] AC_FF = 2'd3;

    localparam int unsigned N_ANSI  = 16;
    localparam int unsigned N_ACODE = 4;
    localparam int unsigned N_GROUP = 4;

    typedef logic [CH_W-1:0] t_ch;

    // ANSI table as per-channel level codes {r, g, b}
    localparam logic [3*ACODE_W-1:0] ANSI_CODE [N_ANSI] = '{
        {AC_00, AC_00, AC_00}, {AC_80, AC_00, AC_00},
        {AC_00, AC_80, AC_00}, {AC_80, AC_80, AC_00},
        {AC_00, AC_00, AC_80}, {AC_80, AC_00, AC_80},
        {AC_00, AC_80, AC_80}, {AC_C0, AC_C0, AC_C0},
        {AC_80, AC_80, AC_80}, {AC_FF, AC_00, AC_00},
        {AC_00, AC_FF, AC_00}, {AC_FF, AC_FF, AC_00},
        {AC_00, AC_00, AC_FF}, {AC_FF, AC_00, AC_FF},
        {AC_00, AC_FF, AC_FF}, {AC_FF, AC_FF, AC_FF}
    };

    // Nearest cube level, ties to the lower level
    function automatic logic [CIDX_W-1:0] cube_snap(input t_ch v);
        logic [CIDX_W-1:0] idx;
        if (v <= 8'd47)       idx = 3'd0;
        else if (v <= 8'd115) idx = 3'd1;
        else if (v <= 8'd155) idx = 3'd2;
        else if (v <= 8'd195) idx = 3'd3;
        else if (v <= 8'd235) idx = 3'd4;
        else                  idx = 3'd5;
        return idx;
    endfunction

    // Cube level value for an index
    function automatic t_ch cube_level(input logic [CIDX_W-1:0] idx);
        t_ch lvl;
        case (idx)
            3'd0:    lvl = 8'd0;
            3'd1:    lvl = 8'd95;
            3'd2:    lvl = 8'd135;
            3'd3:    lvl = 8'd175;
            3'd4:    lvl = 8'd215;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

    // ANSI channel value for a level code
    function automatic t_ch ansi_level(input logic [ACODE_W-1:0] code);
        t_ch lvl;
        case (code)
            AC_00:   lvl = 8'h00;
            AC_80:   lvl = 8'h80;
            AC_C0:   lvl = 8'hC0;
            default: lvl = 8'hFF;
        endcase
        return lvl;
    endfunction

    // Absolute difference of two channel values
    function automatic t_ch abs_diff(input t_ch a, input t_ch b);
        return (a >= b) ? t_ch'(a - b) : t_ch'(b - a);
    endfunction

endpackage

>>> rtl/core/rgb_terminal_palette_quantizer_unit.sv
// Top level: five-stage pipelined RGB to terminal palette index quantizer.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------
//  input   | in        | i_valid / o_stall | i_color_rgb [23:0]
//  output  | out       | o_valid / i_stall | o_palette_index [7:0]
//  config  | in        | i_cfg_we          | i_cfg_data (palette mode)
//
// One item per cycle sustained while i_stall is low.
// Stage 1 snaps channels and sums them, stage 2 divides the sum and squares errors,
// stage 3 forms the grey step and distance sums, stage 4 squares grey errors and
// reduces ANSI groups, stage 5 makes the final choice into the output register.
// Each stage loads when it is empty or the one after it moves, so bubbles collapse.
// o_stall rises only when all five stages hold items and the output is stalled.
// Reset (synchronous, active low) clears the valid bits and sets cube mode.
`timescale 1ns / 1ps

module rgb_terminal_palette_quantizer_unit
    import rtpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COLOR_W-1:0] i_color_rgb,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [INDEX_W-1:0] o_palette_index
);

    // Mode register
    logic r_mode;

    // Stage valid bits and enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // Stage 1 registers
    t_ch              r_rgb1 [3];
    logic             r_mode1;
    logic [CIDX_W-1:0] r_ci1 [3];
    logic [SUM_W-1:0] r_sum1;

    // Stage 2 registers
    t_ch              r_rgb2 [3];
    logic             r_mode2;
    logic [CIDX_W-1:0] r_ci2 [3];
    t_ch              r_mean2;
    logic [CSQ_W-1:0] r_csq2 [3];
    logic [SQ_W-1:0]  r_asq2 [3][N_ACODE];

    // Stage 3 registers
    t_ch               r_rgb3 [3];
    logic              r_mode3;
    logic [CIDX_W-1:0] r_ci3 [3];
    logic [STEP_W-1:0] r_step3;
    logic [CERR_W-1:0] r_cerr3;
    logic [DIST_W-1:0] r_adist3 [N_ANSI];

    // Stage 4 registers
    logic              r_mode4;
    logic [CIDX_W-1:0] r_ci4 [3];
    logic [STEP_W-1:0] r_step4;
    logic [CERR_W-1:0] r_cerr4;
    logic [SQ_W-1:0]   r_gsq4 [3];
    logic [DIST_W-1:0] r_gbest4 [N_GROUP];
    logic [AIDX_W-1:0] r_gidx4 [N_GROUP];

    // Stage 5 (output) register
    logic [INDEX_W-1:0] r_index5;

    // Next values
    t_ch               n_rgb1 [3];
    logic [CIDX_W-1:0] n_ci1 [3];
    logic [SUM_W-1:0]  n_sum1;
    t_ch               n_mean2;
    logic [CSQ_W-1:0]  n_csq2 [3];
    logic [SQ_W-1:0]   n_asq2 [3][N_ACODE];
    logic [STEP_W-1:0] n_step3;
    logic [CERR_W-1:0] n_cerr3;
    logic [DIST_W-1:0] n_adist3 [N_ANSI];
    logic [SQ_W-1:0]   n_gsq4 [3];
    logic [DIST_W-1:0] n_gbest4 [N_GROUP];
    logic [AIDX_W-1:0] n_gidx4 [N_GROUP];
    logic [INDEX_W-1:0] n_index5;

    // Stage enables, back to front
    assign en5     = !r_v5 || !i_stall;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    assign o_valid         = r_v5;
    assign o_palette_index = r_index5;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CUBE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage 1: split channels, snap to cube levels, channel sum
    always_comb begin
        n_rgb1[0] = i_color_rgb[23:16];
        n_rgb1[1] = i_color_rgb[15:8];
        n_rgb1[2] = i_color_rgb[7:0];
        for (int c = 0; c < 3; c++) begin
            n_ci1[c] = cube_snap(n_rgb1[c]);
        end
        n_sum1 = SUM_W'(n_rgb1[0]) + SUM_W'(n_rgb1[1]) + SUM_W'(n_rgb1[2]);
    end

    // Stage 2: mean by reciprocal, cube and ANSI channel squares
    always_comb begin
        logic [2*SUM_W-1:0] mprod;
        logic [SQ_W-1:0]    sq;
        t_ch                d;
        mprod   = r_sum1 * MEAN_RECIP;
        n_mean2 = mprod[MEAN_SHIFT +: CH_W];
        for (int c = 0; c < 3; c++) begin
            d         = abs_diff(r_rgb1[c], cube_level(r_ci1[c]));
            sq        = d * d;
            n_csq2[c] = sq[CSQ_W-1:0];
            for (int k = 0; k < N_ACODE; k++) begin
                d            = abs_diff(r_rgb1[c], ansi_level(ACODE_W'(k)));
                n_asq2[c][k] = d * d;
            end
        end
    end

    // Stage 3: grey step, cube error, ANSI distances
    always_comb begin
        t_ch          m_off;
        logic [SQ_W-1:0] sprod;
        m_off = r_mean2 - GREY_OFS;
        sprod = m_off * STEP_RECIP;
        if (r_mean2 <= GREY_LO)      n_step3 = '0;
        else if (r_mean2 >= GREY_HI) n_step3 = GREY_MAX;
        else                         n_step3 = sprod[STEP_SHIFT +: STEP_W];
        n_cerr3 = CERR_W'(r_csq2[0]) + CERR_W'(r_csq2[1]) + CERR_W'(r_csq2[2]);
        for (int i = 0; i < N_ANSI; i++) begin
            n_adist3[i] = DIST_W'(r_asq2[0][ANSI_CODE[i][5:4]])
                        + DIST_W'(r_asq2[1][ANSI_CODE[i][3:2]])
                        + DIST_W'(r_asq2[2][ANSI_CODE[i][1:0]]);
        end
    end

    // Stage 4: grey channel squares, ANSI minimum within groups of four
    always_comb begin
        t_ch lvl;
        t_ch d;
        lvl = GREY_BASE_L + t_ch'(GREY_STRIDE * t_ch'(r_step3));
        for (int c = 0; c < 3; c++) begin
            d         = abs_diff(r_rgb3[c], lvl);
            n_gsq4[c] = d * d;
        end
        // Strict less keeps the lowest index on ties
        for (int g = 0; g < N_GROUP; g++) begin
            n_gbest4[g] = r_adist3[g*N_GROUP];
            n_gidx4[g]  = AIDX_W'(g*N_GROUP);
            for (int k = 1; k < N_GROUP; k++) begin
                if (r_adist3[g*N_GROUP+k] < n_gbest4[g]) begin
                    n_gbest4[g] = r_adist3[g*N_GROUP+k];
                    n_gidx4[g]  = AIDX_W'(g*N_GROUP+k);
                end
            end
        end
    end

    // Stage 5: final choice
    always_comb begin
        logic [DIST_W-1:0] gerr;
        logic [DIST_W-1:0] abest;
        logic [AIDX_W-1:0] aidx;
        gerr  = DIST_W'(r_gsq4[0]) + DIST_W'(r_gsq4[1]) + DIST_W'(r_gsq4[2]);
        abest = r_gbest4[0];
        aidx  = r_gidx4[0];
        for (int g = 1; g < N_GROUP; g++) begin
            if (r_gbest4[g] < abest) begin
                abest = r_gbest4[g];
                aidx  = r_gidx4[g];
            end
        end
        if (r_mode4 == MODE_ANSI) begin
            n_index5 = INDEX_W'(aidx);
        end else if (gerr < DIST_W'(r_cerr4)) begin
            n_index5 = GREY_BASE + INDEX_W'(r_step4);
        end else begin
            n_index5 = CUBE_BASE
                     + INDEX_W'(CUBE_R_WT * INDEX_W'(r_ci4[0]))
                     + INDEX_W'(CUBE_G_WT * INDEX_W'(r_ci4[1]))
                     + INDEX_W'(r_ci4[2]);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_rgb1  <= n_rgb1;
            r_mode1 <= r_mode;
            r_ci1   <= n_ci1;
            r_sum1  <= n_sum1;
        end
        if (en2) begin
            r_rgb2  <= r_rgb1;
            r_mode2 <= r_mode1;
            r_ci2   <= r_ci1;
            r_mean2 <= n_mean2;
            r_csq2  <= n_csq2;
            r_asq2  <= n_asq2;
        end
        if (en3) begin
            r_rgb3   <= r_rgb2;
            r_mode3  <= r_mode2;
            r_ci3    <= r_ci2;
            r_step3  <= n_step3;
            r_cerr3  <= n_cerr3;
            r_adist3 <= n_adist3;
        end
        if (en4) begin
            r_mode4  <= r_mode3;
            r_ci4    <= r_ci3;
            r_step4  <= r_step3;
            r_cerr4  <= r_cerr3;
            r_gsq4   <= n_gsq4;
            r_gbest4 <= n_gbest4;
            r_gidx4  <= n_gidx4;
        end
        if (en5) begin
            r_index5 <= n_index5;
        end
    end

endmodule

>>> rtl/core/rtpq_checker.sv
// Checker: port-level assertions for the quantizer, bound to the top level.
`timescale 1ns / 1ps

module rtpq_checker
    import rtpq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [INDEX_W-1:0] o_palette_index
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_palette_index)))
        else $error("stalled result changed");

    // Input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // An accepted item is followed by a valid result on the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> ##5 o_valid)
        else $error("no result five cycles after accept");

endmodule

bind rgb_terminal_palette_quantizer_unit rtpq_checker u_rtpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_palette_index (o_palette_index)
);
